/* hw/rtl/dfp_pkg.sv */
// dfp_pkg: shared types and constants for the delimited field parser.
// No dependencies.
package dfp_pkg;

    localparam logic [7:0] QUOTE_BYTE   = 8'd34;
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] COMMA_BYTE   = 8'd44;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_FIELD = 2'd1;
    localparam logic [1:0] KIND_ROW   = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic       eoi;
        logic       is_quote;
        logic       is_sep;
        logic       is_nl;
        logic [7:0] data;
    } dfp_item_t;

endpackage

/* hw/rtl/dfp_front.sv */
// dfp_front: holds the separator register and classifies each input byte.
// Depends on dfp_pkg.
module dfp_front import dfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       req_eoi,
    input  logic [7:0] req_byte,
    output dfp_item_t  item
);

    logic [7:0] sep_reg;
    logic [7:0] sep_next;
    logic [7:0] sep_eff;

    always_comb
    begin
        sep_next = cfg_we ? cfg_wdata : sep_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= COMMA_BYTE;
        end
        else
        begin
            sep_reg <= sep_next;
        end
    end

    // a quote as separator acts as a comma
    assign sep_eff = (sep_reg == QUOTE_BYTE) ? COMMA_BYTE : sep_reg;

    always_comb
    begin
        item.eoi      = req_eoi;
        item.is_quote = (req_byte == QUOTE_BYTE);
        item.is_sep   = (req_byte == sep_eff);
        item.is_nl    = (req_byte == NEWLINE_BYTE);
        item.data     = req_byte;
    end

endmodule

/* hw/rtl/dfp_fifo.sv */
// dfp_fifo: short queue of classified words between front and back.
// Depends on dfp_pkg.
module dfp_fifo import dfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  dfp_item_t push_data,
    output logic      full,
    input  logic      pop,
    output dfp_item_t pop_data,
    output logic      empty
);

    dfp_item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg;
    logic [FIFO_AW-1:0]     wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg;
    logic [FIFO_AW-1:0]     rd_ptr_next;
    logic [FIFO_CW-1:0]     count_reg;
    logic [FIFO_CW-1:0]     count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/dfp_back.sv */
// dfp_back: parse state machine and output register.
// Depends on dfp_pkg.
module dfp_back import dfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  dfp_item_t  q_data,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte
);

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_PLAIN  = 2'd1;
    localparam logic [1:0] MODE_QUOTED = 2'd2;
    localparam logic [1:0] MODE_QSEEN  = 2'd3;

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       row_reg;
    logic       row_next;
    logic       valid_reg;
    logic       valid_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       emit;
    logic [1:0] emit_kind;

    assign q_pop = !q_empty && (!valid_reg || out_ready);

    always_comb
    begin
        mode_next = mode_reg;
        row_next  = row_reg;
        emit      = 1'b0;
        emit_kind = KIND_DATA;
        if (q_data.eoi)
        begin
            mode_next = MODE_START;
            if (row_reg || mode_reg != MODE_START)
            begin
                emit      = 1'b1;
                emit_kind = KIND_ROW;
                row_next  = 1'b0;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_START:
                begin
                    if (q_data.is_quote)
                    begin
                        mode_next = MODE_QUOTED;
                        row_next  = 1'b1;
                    end
                    else if (q_data.is_sep)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_FIELD;
                        row_next  = 1'b1;
                    end
                    else if (q_data.is_nl)
                    begin
                        if (row_reg)
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_ROW;
                            row_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        emit      = 1'b1;
                        mode_next = MODE_PLAIN;
                        row_next  = 1'b1;
                    end
                end
                MODE_PLAIN:
                begin
                    emit = 1'b1;
                    if (!q_data.is_quote && q_data.is_sep)
                    begin
                        emit_kind = KIND_FIELD;
                        mode_next = MODE_START;
                        row_next  = 1'b1;
                    end
                    else if (!q_data.is_quote && q_data.is_nl)
                    begin
                        emit_kind = KIND_ROW;
                        mode_next = MODE_START;
                        row_next  = 1'b0;
                    end
                end
                MODE_QUOTED:
                begin
                    if (q_data.is_quote)
                    begin
                        mode_next = MODE_QSEEN;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                default:
                begin
                    emit = 1'b1;
                    if (q_data.is_quote)
                    begin
                        mode_next = MODE_QUOTED;
                    end
                    else if (q_data.is_sep)
                    begin
                        emit_kind = KIND_FIELD;
                        mode_next = MODE_START;
                        row_next  = 1'b1;
                    end
                    else if (q_data.is_nl)
                    begin
                        emit_kind = KIND_ROW;
                        mode_next = MODE_START;
                        row_next  = 1'b0;
                    end
                    else
                    begin
                        mode_next = MODE_PLAIN;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        if (q_pop && emit)
        begin
            valid_next = 1'b1;
            kind_next  = emit_kind;
            byte_next  = (emit_kind == KIND_DATA) ? q_data.data : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            row_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                mode_reg <= mode_next;
                row_reg  <= row_next;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;

endmodule

/* hw/rtl/delimited_field_parser.sv */
// delimited_field_parser: streaming CSV-style field parser, top level.
// Depends on dfp_pkg, dfp_front, dfp_fifo, dfp_back.
//
// Usage:
//   Slave stream: one word per text byte (tdata) with tuser = 0, or an
//   end-of-input word with tuser = 1 that closes an open row.
//   Master stream: one word per field data byte (tuser = 0, tdata = byte),
//   end of field (tuser = 1) or end of field and row (tuser = 2), tdata zero
//   on marks. An input word gives zero or one output word.
//   cfg_we/cfg_wdata write the field separator (reset ','); write only idle.
//   Throughput: one word per cycle on both sides unless the master stalls.
//   An accepted word is classified by the front into a 4-entry queue, then
//   the back state machine writes its result into an output register.
//   Reset: queue empty, parser at field start with no row open, separator
//   back to ','.
//   Master stall: the output word holds; the queue fills and s_axis_tready
//   drops once it holds four words.
module delimited_field_parser import dfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser    // [1:0] out_kind
);

    dfp_item_t front_item;
    dfp_item_t q_data;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;

    dfp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_eoi   (s_axis_tuser),
        .req_byte  (s_axis_tdata),
        .item      (front_item)
    );

    dfp_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_data (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    dfp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_byte  (m_axis_tdata)
    );

    assign s_axis_tready = !q_full;

    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !q_empty)
        else $error("accepted word not queued");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_DATA || m_axis_tuser == KIND_FIELD
                           || m_axis_tuser == KIND_ROW))
        else $error("illegal output kind");

    a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_DATA) |-> (m_axis_tdata == 8'd0))
        else $error("mark word carries data");

endmodule

/* test/delimited_field_parser_test.sv */
`timescale 1ns / 100ps
// delimited_field_parser_test: self-checking testbench for the delimited field parser.
// Drives text/end-of-input words with random gaps, predicts data/field/row output words.
// Depends on dfp_pkg and delimited_field_parser.
module delimited_field_parser_test;
    import dfp_pkg::*;

    localparam logic REQ_TEXT = 1'b0;
    localparam logic REQ_EOI  = 1'b1;
    localparam logic [7:0] CR_BYTE = 8'h0d;
    localparam int PHASE_ITEMS = 110;
    localparam int SETTLE_CYCLES = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        AT_FIELD_START,
        IN_PLAIN_FIELD,
        IN_QUOTES,
        AFTER_QUOTE
    } parse_mode_t;

    typedef struct packed {
        logic       req;
        logic [7:0] chr;
    } text_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } field_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic       s_axis_tuser = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;

    text_word_t  text_to_send[$];
    field_word_t fields_due[$];
    text_word_t  in_flight;

    logic [7:0]  sep_shadow = COMMA_BYTE;
    parse_mode_t mode_shadow = AT_FIELD_START;
    logic        row_open_shadow = 1'b0;

    int  send_gap = 0;
    int  recv_stall = 0;
    bit  no_idle = 1'b0;
    int  error_count = 0;
    int  idle_cycles = 0;
    int  items_queued = 0;

    delimited_field_parser DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] active_sep();
        return (sep_shadow == QUOTE_BYTE) ? COMMA_BYTE : sep_shadow;
    endfunction

    // Advances the parser shadow by one word; returns 1 when a field word results.
    function automatic bit parse_step(input text_word_t w, output field_word_t r);
        logic [7:0] sep;
        sep = active_sep();
        r = '0;
        if (w.req == REQ_EOI)
        begin
            if (row_open_shadow || mode_shadow != AT_FIELD_START)
            begin
                mode_shadow = AT_FIELD_START;
                row_open_shadow = 1'b0;
                r.kind = KIND_ROW;
                return 1'b1;
            end
            mode_shadow = AT_FIELD_START;
            return 1'b0;
        end
        case (mode_shadow)
            AT_FIELD_START:
            begin
                if (w.chr == QUOTE_BYTE)
                begin
                    mode_shadow = IN_QUOTES;
                    row_open_shadow = 1'b1;
                    return 1'b0;
                end
                if (w.chr == NEWLINE_BYTE && w.chr != sep && !row_open_shadow)
                    return 1'b0;
            end
            IN_QUOTES:
            begin
                if (w.chr == QUOTE_BYTE)
                begin
                    mode_shadow = AFTER_QUOTE;
                    return 1'b0;
                end
                r.kind = KIND_DATA;
                r.data = w.chr;
                return 1'b1;
            end
            AFTER_QUOTE:
            begin
                if (w.chr == QUOTE_BYTE)
                begin
                    mode_shadow = IN_QUOTES;
                    r.kind = KIND_DATA;
                    r.data = w.chr;
                    return 1'b1;
                end
            end
            default:
            begin
                if (w.chr == QUOTE_BYTE)
                begin
                    r.kind = KIND_DATA;
                    r.data = w.chr;
                    return 1'b1;
                end
            end
        endcase
        // separator, newline or plain data outside quotes
        if (w.chr == sep)
        begin
            mode_shadow = AT_FIELD_START;
            row_open_shadow = 1'b1;
            r.kind = KIND_FIELD;
        end
        else if (w.chr == NEWLINE_BYTE)
        begin
            mode_shadow = AT_FIELD_START;
            row_open_shadow = 1'b0;
            r.kind = KIND_ROW;
        end
        else
        begin
            mode_shadow = IN_PLAIN_FIELD;
            row_open_shadow = 1'b1;
            r.kind = KIND_DATA;
            r.data = w.chr;
        end
        return 1'b1;
    endfunction

    // driver
    always @(posedge clk)
    begin
        field_word_t word;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (parse_step(in_flight, word))
                    fields_due = {fields_due, word};
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (text_to_send.size() > 0)
                begin
                    in_flight = text_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= in_flight.chr;
                    s_axis_tuser <= in_flight.req;
                    if (!no_idle && $urandom_range(0, 15) == 0)
                        send_gap = $urandom_range(1, 19);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        field_word_t due;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (fields_due.size() == 0)
                begin
                    $error("unexpected word: out_kind %0d out_byte 0x%02h",
                           m_axis_tuser, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    due = fields_due.pop_front();
                    if (m_axis_tuser !== due.kind)
                    begin
                        $error("out_kind: expected %0d, actual %0d", due.kind, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata !== due.data)
                    begin
                        $error("out_byte: expected 0x%02h, actual 0x%02h",
                               due.data, m_axis_tdata);
                        error_count++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 15) == 0)
                    recv_stall = $urandom_range(1, 19);
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic push_text(input logic [7:0] b);
        text_word_t w;
        w.req = REQ_TEXT;
        w.chr = b;
        text_to_send = {text_to_send, w};
        items_queued++;
    endtask

    task automatic push_eoi();
        text_word_t w;
        w.req = REQ_EOI;
        w.chr = 8'($urandom_range(0, 255));
        text_to_send = {text_to_send, w};
        items_queued++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_text(s[i]);
    endtask

    function automatic logic [7:0] pick_content();
        case ($urandom_range(0, 15))
            0: return QUOTE_BYTE;
            1: return sep_shadow;
            2: return NEWLINE_BYTE;
            3: return CR_BYTE;
            4: return 8'h00;
            5: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_row();
        int nfields;
        int len;
        logic [7:0] b;
        nfields = $urandom_range(1, 5);
        for (int f = 0; f < nfields; f++)
        begin
            if (f > 0)
                push_text(active_sep());
            len = $urandom_range(0, 6);
            if ($urandom_range(0, 2) == 0)
            begin
                push_text(QUOTE_BYTE);
                for (int i = 0; i < len; i++)
                begin
                    b = pick_content();
                    push_text(b);
                    if (b == QUOTE_BYTE)
                        push_text(b);
                end
                push_text(QUOTE_BYTE);
            end
            else
            begin
                for (int i = 0; i < len; i++)
                begin
                    do
                        b = pick_content();
                    while (b == active_sep() || b == NEWLINE_BYTE);
                    push_text(b);
                end
            end
        end
        case ($urandom_range(0, 9))
            0: push_eoi();
            1:
            begin
                push_text(active_sep());
                push_text(NEWLINE_BYTE);
            end
            2:
            begin
                push_text(NEWLINE_BYTE);
                push_text(NEWLINE_BYTE);
            end
            default: push_text(NEWLINE_BYTE);
        endcase
    endtask

    task automatic push_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                push_eoi();
            else
                push_text(pick_content());
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (text_to_send.size() != 0 || s_axis_tvalid || fields_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_separator(input logic [7:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sep_shadow = value;
    endtask

    task automatic run_phase(input logic [7:0] sep);
        int stop_at;
        write_separator(sep);
        stop_at = items_queued + PHASE_ITEMS;
        while (items_queued < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                push_noise();
            else
                push_row();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: quoting corner cases with the default separator
        write_separator(COMMA_BYTE);
        push_str("a");
        push_text(8'h00);
        push_text(8'hff);
        push_str("\",");
        push_str("\"\"\"x\",");
        push_str("\"\",");
        push_str("\"\n,\"y\n");
        push_str("\n");
        push_str("b,\n");
        push_text(CR_BYTE);
        push_eoi();
        push_eoi();
        push_str("\"z");
        push_eoi();
        wait_drained();

        run_phase(8'd59);
        run_phase(8'd9);
        run_phase(8'h00);
        run_phase(8'hff);
        run_phase(QUOTE_BYTE);
        run_phase(NEWLINE_BYTE);
        run_phase(COMMA_BYTE);
        no_idle = 1'b1;
        run_phase(8'($urandom_range(0, 255)));

        if (error_count == 0 && fields_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* delimited_field_parser.f */
hw/rtl/dfp_pkg.sv
hw/rtl/dfp_front.sv
hw/rtl/dfp_fifo.sv
hw/rtl/dfp_back.sv
hw/rtl/delimited_field_parser.sv
test/delimited_field_parser_test.sv
